@@ rtl/counting_semaphore_wait_queue_unit_defines.svh @@
// Assertion helpers for the counting semaphore wait queue unit.
// Each macro samples on the rising edge of clock and is off while reset is high.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CSW_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CSW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/csw_pkg.sv @@
`timescale 1ns / 1ps
package csw_pkg;

   // request / response field widths
   localparam int FUNC_W   = 2;
   localparam int TASK_W   = 8;
   localparam int INIT_W   = 15;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DOWN    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UP      = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // count limits
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;
   localparam logic signed [COUNT_W-1:0] COUNT_ONE = 16'sd1;

endpackage

@@ rtl/csw_ram.sv @@
`timescale 1ns / 1ps
// Wait queue storage: one write port, one read port, registered read data.
module csw_ram #(
   parameter int Depth = 16,
   parameter int Width = 8,
   parameter int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/counting_semaphore_wait_queue_unit.sv @@
`timescale 1ns / 1ps
// Counting semaphore with a FIFO wait queue of task ids.
// Request channel (req_*): func selects create, down, up or destroy; task_id is
// the caller, queued when a down blocks; init_value is the count for create.
// Response channel (rsp_*): status, caller_blocked, woken task info and last.
// Every request gives one response, except destroy with waiters queued: one
// response per waiter (oldest first, woken_by_destroy set), last on the final one.
// Timing: a request is taken in ST_IDLE, executed against the semaphore
// state in ST_EXEC, and its result is held in ST_EMIT until the output
// register is free, then registered as the response. req_ready returns
// when the response is loaded into the output register.
// A destroy sweep drains the queue at one waiter per cycle while the
// receiver keeps up, each one a read of the queue memory at the head pointer.
// A wake reads the queue memory once, in ST_EXEC or (destroy sweep) ST_EMIT;
// writes (down) and reads (up, destroy) never share a request: no forwarding.
// Reset clears the semaphore to inactive with an empty queue; queue contents
// are not cleared, the head/tail pointers and fill count track what is valid.
// While the receiver stalls, the response stays put and the unit waits with
// the next result; no request is accepted until the pending one is handed off.
module counting_semaphore_wait_queue_unit #(
   parameter int MAX_WAITERS  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [csw_pkg::FUNC_W-1:0]     req_func,
   input  logic [csw_pkg::TASK_W-1:0]     req_task_id,
   input  logic [csw_pkg::INIT_W-1:0]     req_init_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [csw_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_caller_blocked,
   output logic                           rsp_woken_valid,
   output logic [csw_pkg::TASK_W-1:0]     rsp_woken_task,
   output logic                           rsp_woken_by_destroy,
   output logic                           rsp_last
);
   import csw_pkg::*;

   localparam int AddrW    = $clog2(MAX_WAITERS);
   localparam int FillW    = $clog2(MAX_WAITERS + 1);
   localparam int KeepBits = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;

   // semaphore state
   logic                       active_ff, active_in;
   logic signed [COUNT_W-1:0]  count_ff, count_in;
   logic [AddrW-1:0]           head_ff, head_in;
   logic [AddrW-1:0]           tail_ff, tail_in;
   logic [FillW-1:0]           fill_ff, fill_in;

   // captured request
   logic [FUNC_W-1:0]          op_func_ff, op_func_in;
   logic [TASK_W-1:0]          op_task_ff, op_task_in;
   logic [INIT_W-1:0]          op_init_ff, op_init_in;

   // pending result
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic                       res_blocked_ff, res_blocked_in;
   logic                       res_wake_ff, res_wake_in;
   logic                       res_destroy_ff, res_destroy_in;
   logic                       res_last_ff, res_last_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                       rsp_blocked_ff, rsp_blocked_in;
   logic                       rsp_wvalid_ff, rsp_wvalid_in;
   logic [TASK_W-1:0]          rsp_wtask_ff, rsp_wtask_in;
   logic                       rsp_bydestroy_ff, rsp_bydestroy_in;
   logic                       rsp_last_ff, rsp_last_in;

   // queue memory port
   logic                       wr_en;
   logic [TASK_ID_BITS-1:0]    wr_data;
   logic                       rd_en;
   logic [TASK_ID_BITS-1:0]    rd_data;

   logic signed [COUNT_W-1:0]  count_inc;
   logic                       count_le0;
   logic                       inc_le0;
   logic                       out_free;
   logic [AddrW-1:0]           head_next;
   logic [AddrW-1:0]           tail_next;

   csw_ram #(
      .Depth (MAX_WAITERS),
      .Width (TASK_ID_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // saturating increment, sign tests
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;
   assign count_le0 = count_ff[COUNT_W-1] || (count_ff == '0);
   assign inc_le0   = count_inc[COUNT_W-1] || (count_inc == '0);

   // circular pointer wrap at MAX_WAITERS
   assign head_next = (head_ff == AddrW'(MAX_WAITERS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == AddrW'(MAX_WAITERS - 1)) ? '0 : tail_ff + 1'b1;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign wr_data  = TASK_ID_BITS'(op_task_ff[KeepBits-1:0]);

   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      count_in         = count_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      fill_in          = fill_ff;
      op_func_in       = op_func_ff;
      op_task_in       = op_task_ff;
      op_init_in       = op_init_ff;
      res_status_in    = res_status_ff;
      res_blocked_in   = res_blocked_ff;
      res_wake_in      = res_wake_ff;
      res_destroy_in   = res_destroy_ff;
      res_last_in      = res_last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_status_in    = rsp_status_ff;
      rsp_blocked_in   = rsp_blocked_ff;
      rsp_wvalid_in    = rsp_wvalid_ff;
      rsp_wtask_in     = rsp_wtask_ff;
      rsp_bydestroy_in = rsp_bydestroy_ff;
      rsp_last_in      = rsp_last_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_func_in = req_func;
               op_task_in = req_task_id;
               op_init_in = req_init_value;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_status_in  = STATUS_OK;
            res_blocked_in = 1'b0;
            res_wake_in    = 1'b0;
            res_destroy_in = 1'b0;
            res_last_in    = 1'b1;
            state_in       = ST_EMIT;
            if (op_func_ff == FUNC_CREATE) begin
               if (active_ff) begin
                  res_status_in = STATUS_STATE;
               end else begin
                  active_in = 1'b1;
                  count_in  = COUNT_W'(op_init_ff);
                  head_in   = '0;
                  tail_in   = '0;
                  fill_in   = '0;
               end
            end else if (!active_ff) begin
               res_status_in = STATUS_STATE;
            end else begin
               case (op_func_ff)
                  FUNC_DOWN: begin
                     if (!count_le0) begin
                        count_in = count_ff - COUNT_ONE;
                     end else if (fill_ff == FillW'(MAX_WAITERS)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        tail_in        = tail_next;
                        fill_in        = fill_ff + 1'b1;
                        count_in       = count_ff - COUNT_ONE;
                        res_blocked_in = 1'b1;
                     end
                  end
                  FUNC_UP: begin
                     count_in = count_inc;
                     if (inc_le0 && (fill_ff != '0)) begin
                        rd_en       = 1'b1;
                        head_in     = head_next;
                        fill_in     = fill_ff - 1'b1;
                        res_wake_in = 1'b1;
                     end
                  end
                  FUNC_DESTROY: begin
                     if (fill_ff == '0) begin
                        active_in = 1'b0;
                        head_in   = '0;
                        tail_in   = '0;
                     end else begin
                        rd_en          = 1'b1;
                        count_in       = count_inc;
                        head_in        = head_next;
                        fill_in        = fill_ff - 1'b1;
                        res_wake_in    = 1'b1;
                        res_destroy_in = 1'b1;
                        res_last_in    = (fill_ff == FillW'(1));
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_blocked_in   = res_blocked_ff;
               rsp_wvalid_in    = res_wake_ff;
               rsp_wtask_in     = res_wake_ff ? TASK_W'(rd_data[KeepBits-1:0]) : '0;
               rsp_bydestroy_in = res_destroy_ff;
               rsp_last_in      = res_last_ff;
               if (res_destroy_ff && !res_last_ff) begin
                  // next waiter of the destroy sweep; old data already captured
                  rd_en       = 1'b1;
                  count_in    = count_inc;
                  head_in     = head_next;
                  fill_in     = fill_ff - 1'b1;
                  res_last_in = (fill_ff == FillW'(1));
               end else begin
                  if (res_destroy_ff) begin
                     active_in = 1'b0;
                     head_in   = '0;
                     tail_in   = '0;
                     fill_in   = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_func_ff       <= op_func_in;
      op_task_ff       <= op_task_in;
      op_init_ff       <= op_init_in;
      res_status_ff    <= res_status_in;
      res_blocked_ff   <= res_blocked_in;
      res_wake_ff      <= res_wake_in;
      res_destroy_ff   <= res_destroy_in;
      res_last_ff      <= res_last_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_blocked_ff   <= rsp_blocked_in;
      rsp_wvalid_ff    <= rsp_wvalid_in;
      rsp_wtask_ff     <= rsp_wtask_in;
      rsp_bydestroy_ff <= rsp_bydestroy_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_caller_blocked   = rsp_blocked_ff;
   assign rsp_woken_valid      = rsp_wvalid_ff;
   assign rsp_woken_task       = rsp_wtask_ff;
   assign rsp_woken_by_destroy = rsp_bydestroy_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

@@ rtl/csw_checker.sv @@
`timescale 1ns / 1ps
`include "counting_semaphore_wait_queue_unit_defines.svh"
module csw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [csw_pkg::FUNC_W-1:0]   req_func,
   input logic [csw_pkg::TASK_W-1:0]   req_task_id,
   input logic [csw_pkg::INIT_W-1:0]   req_init_value,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [csw_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_caller_blocked,
   input logic                         rsp_woken_valid,
   input logic [csw_pkg::TASK_W-1:0]   rsp_woken_task,
   input logic                         rsp_woken_by_destroy,
   input logic                         rsp_last
);
   import csw_pkg::*;

   // stalled response holds
   `CSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_woken_task) && $stable(rsp_last) && $stable(rsp_woken_valid), "response changed while stalled")

   // one request in flight: ready drops after a take
   `CSW_ASSERT_NEXT(a_one_inflight, req_valid && req_ready, !req_ready, "request taken while busy")

   // an error ends the operation and wakes nobody
   `CSW_ASSERT_NOW(a_err_clean, rsp_valid && (rsp_status != STATUS_OK), rsp_last && !rsp_woken_valid && !rsp_caller_blocked, "error response carries side effects")

   // only a destroy sweep spreads over several responses
   `CSW_ASSERT_NOW(a_multi_destroy, rsp_valid && !rsp_last, rsp_woken_by_destroy && rsp_woken_valid, "non-final response outside destroy")

   // a blocked caller is never woken in the same response
   `CSW_ASSERT_NOW(a_block_excl, rsp_valid && rsp_caller_blocked, !rsp_woken_valid && (rsp_status == STATUS_OK), "blocked and woken together")

endmodule

bind counting_semaphore_wait_queue_unit csw_checker u_csw_checker (.*);
